// ===== hw/rtl/gbpf_pkg.sv =====
// Shared types, constants and prime/reciprocal tables for the gcd core.
package gbpf_pkg;

  localparam int unsigned ValueBitsDefault  = 13;
  localparam int unsigned PrimeCountDefault = 26;
  localparam int unsigned TableSize         = 26;
  localparam int unsigned IdxW              = $clog2(TableSize);
  localparam int unsigned PrimeW            = 7;
  localparam int unsigned RecipW            = 20;
  localparam int unsigned RecipShift        = 20;

  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [PrimeW-1:0] prime_t;
  typedef logic [RecipW-1:0] recip_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CHECK,
    OP_MUL,
    OP_STRIP,
    OP_INC,
    OP_FINAL,
    OP_EMIT
  } op_e;

  typedef struct packed {
    logic zero;
    logic any_div;
    logic last;
    logic out_busy;
  } status_t;

  function automatic prime_t prime_at(idx_t i);
    prime_t p;
    case (i)
      5'd0:    p = 7'd2;
      5'd1:    p = 7'd3;
      5'd2:    p = 7'd5;
      5'd3:    p = 7'd7;
      5'd4:    p = 7'd11;
      5'd5:    p = 7'd13;
      5'd6:    p = 7'd17;
      5'd7:    p = 7'd19;
      5'd8:    p = 7'd23;
      5'd9:    p = 7'd29;
      5'd10:   p = 7'd31;
      5'd11:   p = 7'd37;
      5'd12:   p = 7'd41;
      5'd13:   p = 7'd43;
      5'd14:   p = 7'd47;
      5'd15:   p = 7'd53;
      5'd16:   p = 7'd59;
      5'd17:   p = 7'd61;
      5'd18:   p = 7'd67;
      5'd19:   p = 7'd71;
      5'd20:   p = 7'd73;
      5'd21:   p = 7'd79;
      5'd22:   p = 7'd83;
      5'd23:   p = 7'd89;
      5'd24:   p = 7'd97;
      5'd25:   p = 7'd101;
      default: p = 7'd2;
    endcase
    return p;
  endfunction

  // ceil(2^RecipShift / p); exact floor quotient for operands below 2^13
  function automatic recip_t recip_at(idx_t i);
    recip_t m;
    case (i)
      5'd0:    m = 20'd524288;
      5'd1:    m = 20'd349526;
      5'd2:    m = 20'd209716;
      5'd3:    m = 20'd149797;
      5'd4:    m = 20'd95326;
      5'd5:    m = 20'd80660;
      5'd6:    m = 20'd61681;
      5'd7:    m = 20'd55189;
      5'd8:    m = 20'd45591;
      5'd9:    m = 20'd36158;
      5'd10:   m = 20'd33826;
      5'd11:   m = 20'd28340;
      5'd12:   m = 20'd25576;
      5'd13:   m = 20'd24386;
      5'd14:   m = 20'd22311;
      5'd15:   m = 20'd19785;
      5'd16:   m = 20'd17773;
      5'd17:   m = 20'd17190;
      5'd18:   m = 20'd15651;
      5'd19:   m = 20'd14769;
      5'd20:   m = 20'd14365;
      5'd21:   m = 20'd13274;
      5'd22:   m = 20'd12634;
      5'd23:   m = 20'd11782;
      5'd24:   m = 20'd10811;
      5'd25:   m = 20'd10382;
      default: m = 20'd524288;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/gbpf_sequencer.sv =====
// Microcode ROM, step counter and jump logic for the gcd core.
module gbpf_sequencer import gbpf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t status_i,
  output op_e     op_o,
  output logic    in_stall_o
);

  typedef logic [2:0] step_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_ITEM,
    COND_ZERO,
    COND_ANY_DIV,
    COND_LAST,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
    step_t next;
  } uword_t;

  localparam step_t StLoad  = 3'd0;
  localparam step_t StCheck = 3'd1;
  localparam step_t StMul   = 3'd2;
  localparam step_t StTest  = 3'd3;
  localparam step_t StNextP = 3'd4;
  localparam step_t StFinal = 3'd5;
  localparam step_t StEmit  = 3'd6;

  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    case (s)
      StLoad:  w = '{op: OP_LOAD,  cond: COND_NO_ITEM,  target: StLoad,  next: StCheck};
      StCheck: w = '{op: OP_CHECK, cond: COND_ZERO,     target: StEmit,  next: StMul};
      StMul:   w = '{op: OP_MUL,   cond: COND_NEVER,    target: StLoad,  next: StTest};
      StTest:  w = '{op: OP_STRIP, cond: COND_ANY_DIV,  target: StMul,   next: StNextP};
      StNextP: w = '{op: OP_INC,   cond: COND_LAST,     target: StFinal, next: StMul};
      StFinal: w = '{op: OP_FINAL, cond: COND_NEVER,    target: StLoad,  next: StEmit};
      StEmit:  w = '{op: OP_EMIT,  cond: COND_OUT_BUSY, target: StEmit,  next: StLoad};
      default: w = '{op: OP_NONE,  cond: COND_NEVER,    target: StLoad,  next: StLoad};
    endcase
    return w;
  endfunction

  step_t  step_q, step_d;
  uword_t uw;
  logic   taken;

  always_comb begin
    uw = ucode_rom(step_q);
    case (uw.cond)
      COND_NEVER:    taken = 1'b0;
      COND_NO_ITEM:  taken = !in_valid_i;
      COND_ZERO:     taken = status_i.zero;
      COND_ANY_DIV:  taken = status_i.any_div;
      COND_LAST:     taken = status_i.last;
      COND_OUT_BUSY: taken = status_i.out_busy;
      default:       taken = 1'b0;
    endcase
    step_d = taken ? uw.target : uw.next;
    if ((uw.op == OP_LOAD && !in_valid_i) || (uw.op == OP_EMIT && status_i.out_busy)) begin
      op_o = OP_NONE;
    end else begin
      op_o = uw.op;
    end
  end

  assign in_stall_o = (step_q != StLoad);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StLoad;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== hw/rtl/gbpf_datapath.sv =====
// Operand, quotient and product registers plus output register of the gcd core.
module gbpf_datapath import gbpf_pkg::*; #(
  parameter int unsigned VALUE_BITS  = ValueBitsDefault,
  parameter int unsigned PRIME_COUNT = PrimeCountDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  op_e                   op_i,
  input  logic [VALUE_BITS-1:0] value_a_i,
  input  logic [VALUE_BITS-1:0] value_b_i,
  input  logic                  out_stall_i,
  output status_t               status_o,
  output logic                  out_valid_o,
  output logic [VALUE_BITS-1:0] divisor_o,
  output logic                  zero_error_o
);

  localparam int unsigned ProdW = VALUE_BITS + RecipW;
  localparam int unsigned ChkW  = VALUE_BITS + PrimeW;

  logic [VALUE_BITS-1:0] a_q, b_q, g_q, qa_q, qb_q;
  idx_t                  i_q;
  logic                  err_q;
  logic                  out_valid_q;
  logic [VALUE_BITS-1:0] divisor_q;
  logic                  zero_error_q;

  prime_t                  p;
  recip_t                  m;
  logic [ProdW-1:0]        prod_a, prod_b;
  logic [ChkW-1:0]         back_a, back_b, gp;
  logic [2*VALUE_BITS-1:0] ga;
  logic                    da, db, zero;

  always_comb begin
    p      = prime_at(i_q);
    m      = recip_at(i_q);
    prod_a = ProdW'(a_q) * ProdW'(m);
    prod_b = ProdW'(b_q) * ProdW'(m);
    back_a = ChkW'(qa_q) * ChkW'(p);
    back_b = ChkW'(qb_q) * ChkW'(p);
    gp     = ChkW'(g_q) * ChkW'(p);
    ga     = (2*VALUE_BITS)'(g_q) * (2*VALUE_BITS)'(a_q);
    da     = (back_a == ChkW'(a_q));
    db     = (back_b == ChkW'(b_q));
    zero   = (a_q == '0) || (b_q == '0);
  end

  assign status_o.zero     = zero;
  assign status_o.any_div  = da || db;
  assign status_o.last     = (i_q == IdxW'(PRIME_COUNT - 1));
  assign status_o.out_busy = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        a_q <= value_a_i;
        b_q <= value_b_i;
        g_q <= VALUE_BITS'(1);
        i_q <= '0;
      end
      OP_CHECK: begin
        err_q <= zero;
        if (zero) begin
          g_q <= '0;
        end
      end
      OP_MUL: begin
        qa_q <= prod_a[RecipShift +: VALUE_BITS];
        qb_q <= prod_b[RecipShift +: VALUE_BITS];
      end
      OP_STRIP: begin
        if (da) begin
          a_q <= qa_q;
        end
        if (db) begin
          b_q <= qb_q;
        end
        if (da && db) begin
          g_q <= gp[VALUE_BITS-1:0];
        end
      end
      OP_INC: begin
        i_q <= i_q + IdxW'(1);
      end
      OP_FINAL: begin
        if (a_q > VALUE_BITS'(1) && a_q == b_q) begin
          g_q <= ga[VALUE_BITS-1:0];
        end
      end
      OP_EMIT: begin
        divisor_q    <= g_q;
        zero_error_q <= err_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign divisor_o    = divisor_q;
  assign zero_error_o = zero_error_q;

endmodule

// ===== hw/rtl/gcd_by_prime_factorization_core.sv =====
// Steps: load, then a zero check that goes straight to emit when an operand is zero; else, per
// prime, a reciprocal multiply and a check-multiply strip step, repeated while either operand is
// divisible, then an index step; after the last prime a final step and emit. The strip passes per
// prime are the larger of the two operand multiplicities; the full table holds 26 primes.
// One transaction at a time, taken in the load step; a finished result waits in the output register.
// Reset: asynchronous active-low; sequencer returns to load, output valid clears.
module gcd_by_prime_factorization_core import gbpf_pkg::*; #(
  parameter int unsigned VALUE_BITS  = ValueBitsDefault,
  parameter int unsigned PRIME_COUNT = PrimeCountDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_a_i,
  input  logic [VALUE_BITS-1:0] value_b_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VALUE_BITS-1:0] divisor_o,
  output logic                  zero_error_o
);

  op_e     op;
  status_t status;

  gbpf_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .op_o       (op),
    .in_stall_o (in_stall_o)
  );

  gbpf_datapath #(
    .VALUE_BITS  (VALUE_BITS),
    .PRIME_COUNT (PRIME_COUNT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .value_a_i    (value_a_i),
    .value_b_i    (value_b_i),
    .out_stall_i  (out_stall_i),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .divisor_o    (divisor_o),
    .zero_error_o (zero_error_o)
  );

endmodule

// ===== hw/rtl/gbpf_checker.sv =====
// Port-level assertions for the gcd core and their bind.
module gbpf_checker import gbpf_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDefault
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [VALUE_BITS-1:0] value_a_i,
  input logic [VALUE_BITS-1:0] value_b_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [VALUE_BITS-1:0] divisor_o,
  input logic                  zero_error_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(value_a_i) && $stable(value_b_i))
    else $error("stalled transaction changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(divisor_o) && $stable(zero_error_o))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_error_o |-> divisor_o == '0)
    else $error("error result with nonzero divisor");

  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !zero_error_o |-> divisor_o != '0)
    else $error("good result with zero divisor");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("new transaction taken while one is in work");

endmodule

bind gcd_by_prime_factorization_core gbpf_checker #(.VALUE_BITS(VALUE_BITS)) u_gbpf_checker (.*);
